// ===== hw/rtl/sfm_pkg.sv =====
`timescale 1ns / 1ps

package sfm_pkg;

   // Needle storage and the cell row.
   localparam int MAX_NEEDLE   = 32;
   localparam int NEEDLE_WORDS = 4;
   localparam int WORD_BITS    = 64;
   localparam int WORD_SEL_BITS = 2;
   localparam int LEN_BITS     = 6;
   localparam int NIDX_BITS    = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;

   // Byte position counter.
   localparam int OFFSET_BITS  = 16;
   localparam int RSP_OFF_BITS = 16;

   // Configuration port.
   localparam int CSR_IDX_BITS = 3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NEEDLE_LO     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NEEDLE_MID_LO = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NEEDLE_MID_HI = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NEEDLE_HI     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NEEDLE_LEN    = 3'd4;

   // Control that every cell of the row sees in the same cycle.
   typedef struct packed {
      logic shift;   // take the neighbor's bit and compare the new byte
      logic clear;   // end of string: drop every partial match
   } cell_ctrl_type;

   // One result as it waits in the output buffer.
   typedef struct packed {
      logic                    found;
      logic                    overflow;
      logic [RSP_OFF_BITS-1:0] offset;
   } rsp_type;

endpackage

// ===== hw/rtl/sfm_cell.sv =====
`timescale 1ns / 1ps

module sfm_cell
   import sfm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic [7:0]    haystack_byte,
   input  logic [7:0]    needle_byte,
   input  logic          active,
   input  logic          prev_match,
   output logic          match_next,
   output logic          match_ff
);

   logic match_in;

   // Needle bytes 0..k end at this byte when bytes 0..k-1 ended at the previous one.
   assign match_next = prev_match & active & (needle_byte == haystack_byte);

   always_comb begin
      match_in = match_ff;
      if (ctrl.clear) begin
         match_in = 1'b0;
      end else if (ctrl.shift) begin
         match_in = match_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

endmodule

// ===== hw/rtl/substring_first_match_unit.sv =====
`timescale 1ns / 1ps

// Streaming first-occurrence substring search. The searched string arrives one
// byte per request on req_tdata, with req_tlast on its final byte; the needle of up
// to 32 bytes and its length are written beforehand through the csr_ port (a length
// above 32 counts as 32). A row of 32 identical cells, one per needle byte, keeps a
// shift-and vector: cell k holds whether needle bytes 0..k end at the current byte
// and passes that bit to cell k+1 on each byte until a hit. The block takes one byte
// every clock cycle while req_tready is high; the compare across the cell row and the
// offset subtract are combinational, and a result is registered in the output buffer
// before it appears on rsp_. The first full occurrence gives one response with found
// set in rsp_tuser and its start offset; if the string ends without one, the last
// byte gives a response with found clear and offset zero. An empty needle matches at
// offset zero on the first byte. After a hit the remaining bytes give nothing. The
// last byte always returns the block to its start state. The position counter stops
// at 65535, and offset_overflow then flags that the reported offset is not exact. A
// two-entry output buffer lets requests keep flowing while a response waits; req_tready
// falls only when both entries hold responses. Write the configuration only while idle.
module substring_first_match_unit
   import sfm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // Request channel.
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // [7:0] haystack_byte
   input  logic                    req_tlast,   // last_byte
   // Response channel.
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [23:0]             rsp_tdata,   // [15:0] match_offset, [16] offset_overflow
   output logic                    rsp_tuser,   // [0] found
   // Configuration write port.
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]    csr_wdata
);

   localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

   // Configuration registers.
   logic [NEEDLE_WORDS-1:0][WORD_BITS-1:0] needle_ff;
   logic [LEN_BITS-1:0]                    length_ff;

   // Per-string state.
   logic [OFFSET_BITS-1:0] count_ff;
   logic [OFFSET_BITS-1:0] count_in;
   logic                   sat_ff;
   logic                   sat_in;
   logic                   reported_ff;
   logic                   reported_in;

   // Output buffer: the main entry drives the port, the skid entry backs it up.
   rsp_type main_ff;
   rsp_type main_in;
   logic    main_valid_ff;
   logic    main_valid_in;
   rsp_type skid_ff;
   rsp_type skid_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;

   logic                   accept;
   logic                   take;
   logic [LEN_BITS-1:0]    eff_len;
   logic                   len_zero;
   logic [NIDX_BITS-1:0]   len_m1;
   logic [OFFSET_BITS-1:0] back;
   logic [OFFSET_BITS-1:0] start_off;
   logic [OFFSET_BITS+RSP_OFF_BITS-1:0] start_off_ext;
   logic                   hit;
   logic                   res_valid;
   rsp_type                res;
   cell_ctrl_type          cell_ctrl;

   logic [MAX_NEEDLE-1:0]  match_bits;
   logic [MAX_NEEDLE-1:0]  match_next;
   logic [MAX_NEEDLE-1:0]  cell_active;

   assign req_tready = ~skid_valid_ff;
   assign accept     = req_tvalid & req_tready;
   assign take       = main_valid_ff & rsp_tready;

   // Needle length, clamped to the size of the cell row.
   assign eff_len  = (length_ff > LEN_BITS'(MAX_NEEDLE)) ? LEN_BITS'(MAX_NEEDLE) : length_ff;
   assign len_zero = (eff_len == '0);
   assign len_m1   = NIDX_BITS'(eff_len - LEN_BITS'(1));

   // The cells shift only while a hit is still being looked for; the last byte
   // clears them in any case.
   assign cell_ctrl.shift = accept & ~reported_ff & ~len_zero;
   assign cell_ctrl.clear = accept & req_tlast;

   // The row of match cells. Cell 0 always has a started prefix behind it.
   for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_cell
      logic prev;
      if (k == 0) begin : g_head
         assign prev = 1'b1;
      end else begin : g_link
         assign prev = match_bits[k-1];
      end
      assign cell_active[k] = (LEN_BITS'(k) < eff_len);
      sfm_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (cell_ctrl),
         .haystack_byte (req_tdata),
         .needle_byte   (needle_ff[k / 8][(k % 8) * 8 +: 8]),
         .active        (cell_active[k]),
         .prev_match    (prev),
         .match_next    (match_next[k]),
         .match_ff      (match_bits[k])
      );
   end

   // A full occurrence ends at this byte when the cell of the last needle byte fires.
   assign hit = ~len_zero & match_next[len_m1];

   // Start offset: the current position less the needle length minus one,
   // held at zero if the counter is below it.
   assign back          = OFFSET_BITS'(len_m1);
   assign start_off     = (count_ff >= back) ? (count_ff - back) : '0;
   assign start_off_ext = {{RSP_OFF_BITS{1'b0}}, start_off};

   assign res_valid    = accept & ~reported_ff & (len_zero | hit | req_tlast);
   assign res.found    = len_zero | hit;
   assign res.overflow = sat_ff;
   assign res.offset   = hit ? start_off_ext[RSP_OFF_BITS-1:0] : '0;

   // Per-string state update.
   always_comb begin
      count_in    = count_ff;
      sat_in      = sat_ff;
      reported_in = reported_ff;
      if (accept) begin
         if (req_tlast) begin
            count_in    = '0;
            sat_in      = 1'b0;
            reported_in = 1'b0;
         end else begin
            if (res_valid) begin
               reported_in = 1'b1;
            end
            if (count_ff == COUNT_MAX) begin
               sat_in = 1'b1;
            end else begin
               count_in = count_ff + OFFSET_BITS'(1);
            end
         end
      end
   end

   // Output buffer. A new response can only arrive while the skid entry is empty.
   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (res_valid) begin
            main_in = res;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (main_valid_ff) begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end else begin
            main_in       = res;
            main_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         sat_ff        <= 1'b0;
         reported_ff   <= 1'b0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         sat_ff        <= sat_in;
         reported_ff   <= reported_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   // Configuration writes; indexes past the length register are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         needle_ff <= '0;
         length_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NEEDLE_LO,
            CSR_NEEDLE_MID_LO,
            CSR_NEEDLE_MID_HI,
            CSR_NEEDLE_HI: begin
               needle_ff[csr_index[WORD_SEL_BITS-1:0]] <= csr_wdata;
            end
            CSR_NEEDLE_LEN: begin
               length_ff <= csr_wdata[LEN_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tuser  = main_ff.found;
   assign rsp_tdata  = {7'b0, main_ff.overflow, main_ff.offset};

`ifndef SYNTHESIS
   // The skid entry is only ever filled behind a waiting main entry.
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry holds a response while the main entry is empty");

   // Once a hit is reported, the rest of the string yields no response.
   a_single_report: assert property (@(posedge clock) disable iff (reset)
      reported_ff |-> !res_valid)
      else $error("second response produced for one string");

   // The last byte returns the cell row and the counters to the start state.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (match_bits == '0 && count_ff == '0 && !sat_ff && !reported_ff))
      else $error("string state not cleared after the last byte");

   // The saturation flag is set only with the counter pinned at its top.
   a_sat_pinned: assert property (@(posedge clock) disable iff (reset)
      sat_ff |-> (count_ff == COUNT_MAX))
      else $error("saturation flag set below the counter limit");
`endif

endmodule
